>>> design/assert_macros.svh
// Assertion macros used by the interval statistics module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`endif

>>> design/swis_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Interval statistics package
// Shared widths, opcodes, status bits and payload types.
// ---------------------------------------------------------------------------
package swis_pkg;
  localparam int unsigned IvW  = 24;
  localparam int unsigned CntW = 32;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

  localparam logic [1:0] StatusOccluded = 2'd1;
  localparam int unsigned StatusFailBit = 1;

  typedef struct packed {
    opcode_e         opcode;
    logic [IvW-1:0]  interval_us;
    logic [1:0]      present_status;
  } in_item_t;

  typedef struct packed {
    logic [IvW-1:0]  mean_us;
    logic [IvW-1:0]  median_us;
    logic [IvW-1:0]  p95_us;
    logic [IvW-1:0]  max_us;
    logic [7:0]      window_count;
    logic [CntW-1:0] presented_count;
    logic [CntW-1:0] occluded_count;
    logic [CntW-1:0] failed_count;
  } out_item_t;

  // Control word broadcast from the sequencer to every cell.
  typedef struct packed {
    logic clear;   // drop every entry
    logic insert;  // write the new value into its sorted place in the row
    logic evict;   // remove the entry with the oldest age
    logic shift;   // rotate the row one place towards the head
  } cell_ctrl_t;
endpackage

>>> design/swis_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels carrying the record and result items.
// ---------------------------------------------------------------------------
interface swis_in_if import swis_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swis_out_if import swis_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/sliding_window_interval_stats.sv
`timescale 1ns / 1ps
// A record passes through eviction (only when the window is full), insertion,
// the row rotation and the result state; a clear goes straight to the result state.
// The row rotation reads out the order statistics; the serial mean divider
// runs alongside it, and the rotation waits for it to finish.
// No new item is taken until the result of the last one has been transferred.
// Reset (asynchronous, active low) empties the window and zeroes counters.
// ---------------------------------------------------------------------------
// Sliding window interval statistics
// Sorted cell row with age tags, counters and a serial mean divider.
// ---------------------------------------------------------------------------
module sliding_window_interval_stats import swis_pkg::*; #(
  parameter int unsigned WINDOW = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swis_in_if.sink    in_if,
  swis_out_if.source out_if
);
  `include "assert_macros.svh"

  localparam int unsigned AgeW = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam int unsigned NW   = $clog2(WINDOW + 1);
  localparam int unsigned SumW = IvW + NW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVICT = 5'b00010,
    S_INS   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e          st_q, st_d;
  logic [NW-1:0]   n_q;
  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] pres_q, occ_q, fail_q;
  logic [IvW-1:0]  new_q;
  logic [NW-1:0]   pos_q;
  logic [NW-1:0]   mid;
  logic [IvW-1:0]  med_a_q, med_b_q, p95_q, max_q;
  logic [IvW-1:0]  oldest_q;
  out_item_t       res_q;
  logic            res_valid_q;
  cell_ctrl_t      ctrl;

  logic            c_valid [WINDOW];
  logic [IvW-1:0]  c_val   [WINDOW];
  logic [AgeW-1:0] c_age   [WINDOW];
  logic            c_take  [WINDOW];
  logic            c_gone  [WINDOW];

  // Age of the oldest entry once the window is full.
  logic [AgeW-1:0] evict_age;
  assign evict_age = AgeW'(WINDOW - 1);

  genvar g;
  generate
    for (g = 0; g < WINDOW; g++) begin : g_cell
      logic            pv, nv, pt, after;
      logic [IvW-1:0]  pval, nval;
      logic [AgeW-1:0] page, nage;
      if (g == 0) begin : g_head
        assign pv = 1'b0; assign pval = '0; assign page = '0; assign pt = 1'b0;
      end else begin : g_mid
        assign pv = c_valid[g-1]; assign pval = c_val[g-1];
        assign page = c_age[g-1]; assign pt = c_take[g-1];
      end
      if (g == WINDOW - 1) begin : g_tail
        assign nv = (st_q == S_SCAN) ? c_valid[0] : 1'b0;
        assign nval = c_val[0]; assign nage = c_age[0];
      end else begin : g_body
        assign nv = c_valid[g+1]; assign nval = c_val[g+1];
        assign nage = c_age[g+1];
      end
      // During eviction, a cell pulls when any cell up to it holds the oldest.
      if (g == 0) begin : g_a0
        assign after = c_gone[0];
      end else begin : g_an
        assign after = c_gone[g] || g_cell[g-1].after;
      end
      swis_cell #(.AgeW(AgeW)) u_cell (
        .clk_i, .rst_ni,
        .ctrl_i(ctrl), .new_val_i(new_q), .evict_age_i(evict_age),
        .prev_valid_i(pv), .prev_val_i(pval), .prev_age_i(page),
        .prev_take_i(ctrl.evict ? after : pt), .is_head_i(g == 0),
        .next_valid_i(nv), .next_val_i(nval), .next_age_i(nage),
        .valid_o(c_valid[g]), .val_o(c_val[g]), .age_o(c_age[g]),
        .take_o(c_take[g]), .gone_o(c_gone[g])
      );
    end
  endgenerate

  // Divider for the mean.
  logic            div_start, div_busy;
  logic [SumW-1:0] div_quo;
  swis_div #(.NumW(SumW), .DenW(NW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(sum_q), .den_i(n_q),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  logic accept;
  assign accept       = in_if.valid && in_if.ready;
  assign in_if.ready  = (st_q == S_IDLE) && !res_valid_q;
  assign out_if.valid = res_valid_q;
  assign out_if.data  = res_q;

  // Oldest value (age WINDOW-1), found combinationally before eviction.
  always_comb begin
    oldest_q = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (c_gone[i]) oldest_q = c_val[i];
    end
  end

  // Rank numerator of the 95th percentile; the rank is the last scan position
  // whose hundredfold value does not exceed it.
  logic [NW+6:0] rank_w;
  assign rank_w = ((NW+7)'(95) * (NW+7)'(n_q - NW'(1)) + (NW+7)'(50));

  assign mid = n_q >> 1;

  always_comb begin
    st_d      = st_q;
    ctrl      = '0;
    div_start = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          if (in_if.data.opcode == OP_CLEAR) begin
            ctrl.clear = 1'b1;
            st_d = S_OUT;
          end else if (n_q == NW'(WINDOW)) begin
            st_d = S_EVICT;
          end else begin
            st_d = S_INS;
          end
        end
      end
      S_EVICT: begin
        ctrl.evict = 1'b1;
        st_d = S_INS;
      end
      S_INS: begin
        ctrl.insert = 1'b1;
        st_d = S_SCAN;
      end
      S_SCAN: begin
        // The divider starts once sum and fill count include the new item.
        div_start  = (pos_q == '0);
        ctrl.shift = (pos_q != NW'(WINDOW));
        if (pos_q == NW'(WINDOW) && !div_busy) st_d = S_OUT;
      end
      S_OUT: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      n_q         <= '0;
      sum_q       <= '0;
      pres_q      <= '0;
      occ_q       <= '0;
      fail_q      <= '0;
      res_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == S_OUT) begin
        res_valid_q <= 1'b1;
      end else if (out_if.valid && out_if.ready) begin
        res_valid_q <= 1'b0;
      end
      if (accept) begin
        pos_q <= '0;
        if (in_if.data.opcode == OP_CLEAR) begin
          n_q <= '0; sum_q <= '0; pres_q <= '0; occ_q <= '0; fail_q <= '0;
        end else begin
          pres_q <= pres_q + CntW'(1);
          if (in_if.data.present_status == StatusOccluded) occ_q <= occ_q + CntW'(1);
          if (in_if.data.present_status[StatusFailBit]) fail_q <= fail_q + CntW'(1);
        end
      end
      if (st_q == S_EVICT) sum_q <= sum_q - SumW'(oldest_q);
      if (st_q == S_INS) begin
        sum_q <= sum_q + SumW'(new_q);
        if (n_q != NW'(WINDOW)) n_q <= n_q + NW'(1);
      end
      if (st_q == S_SCAN && pos_q != NW'(WINDOW)) pos_q <= pos_q + NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) new_q <= in_if.data.interval_us;
    // Cell 0 holds the element of sorted rank pos_q during the rotation.
    if (st_q == S_SCAN) begin
      if (n_q != '0 && pos_q == mid - NW'(1)) med_a_q <= c_val[0];
      if (pos_q == mid) med_b_q <= c_val[0];
      if (pos_q < n_q && ((NW+7)'(100) * (NW+7)'(pos_q)) <= rank_w) p95_q <= c_val[0];
      if (pos_q == n_q - NW'(1)) max_q <= c_val[0];
    end
    if (st_q == S_OUT) begin
      res_q.mean_us         <= (n_q == '0) ? '0 : IvW'(div_quo);
      res_q.median_us       <= (n_q == '0) ? '0 :
                               n_q[0] ? med_b_q :
                               IvW'(({1'b0, med_a_q} + {1'b0, med_b_q}) >> 1);
      res_q.p95_us          <= (n_q == '0) ? '0 : p95_q;
      res_q.max_us          <= (n_q == '0) ? '0 : max_q;
      res_q.window_count    <= 8'(n_q);
      res_q.presented_count <= pres_q;
      res_q.occluded_count  <= occ_q;
      res_q.failed_count    <= fail_q;
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, (st_q != S_IDLE) |-> !in_if.ready,
               "input taken while busy")
  `ASSERT_ALWAYS(a_fill_bound, clk_i, rst_ni, n_q <= NW'(WINDOW), "fill count overflow")
  `ASSERT_IMPL(a_out_after, clk_i, rst_ni, (st_q == S_OUT) |=> res_valid_q,
               "result not raised")
endmodule

>>> design/swis_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module swis_div import swis_pkg::*; #(
  parameter int unsigned NumW = 31,
  parameter int unsigned DenW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NumW + 1);

  logic [CW-1:0]   cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   trial;

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      cnt_d = CW'(NumW);
      quo_d = num_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CW'(1);
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule

>>> design/swis_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted row cell
// One slot of the sorted window: value, age and valid flag.
// ---------------------------------------------------------------------------
module swis_cell import swis_pkg::*; #(
  parameter int unsigned AgeW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  logic [IvW-1:0]  new_val_i,
  input  logic [AgeW-1:0] evict_age_i,
  // neighbour towards the head
  input  logic            prev_valid_i,
  input  logic [IvW-1:0]  prev_val_i,
  input  logic [AgeW-1:0] prev_age_i,
  input  logic            prev_take_i,
  input  logic            is_head_i,
  // neighbour towards the tail
  input  logic            next_valid_i,
  input  logic [IvW-1:0]  next_val_i,
  input  logic [AgeW-1:0] next_age_i,
  output logic            valid_o,
  output logic [IvW-1:0]  val_o,
  output logic [AgeW-1:0] age_o,
  output logic            take_o,
  output logic            gone_o
);
  logic            valid_q, valid_d;
  logic [IvW-1:0]  val_q, val_d;
  logic [AgeW-1:0] age_q, age_d;
  logic            hit;

  // take: new value belongs at or before this slot (sorted ascending).
  assign take_o = !valid_q || (new_val_i < val_q);
  // gone: this slot holds the entry that is to be evicted.
  assign hit    = valid_q && (age_q == evict_age_i);
  assign gone_o = hit;

  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    age_d   = age_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.evict) begin
      // Close the gap: the evicted slot and the slots behind it pull from the tail side.
      if (prev_take_i) begin
        valid_d = next_valid_i;
        val_d   = next_val_i;
        age_d   = next_age_i;
      end
    end else if (ctrl_i.insert) begin
      age_d = age_q + AgeW'(1);
      if (take_o) begin
        if (is_head_i || !prev_take_i) begin
          valid_d = 1'b1;
          val_d   = new_val_i;
          age_d   = '0;
        end else begin
          valid_d = prev_valid_i;
          val_d   = prev_val_i;
          age_d   = prev_age_i + AgeW'(1);
        end
      end
    end else if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      val_d   = next_val_i;
      age_d   = next_age_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    age_q <= age_d;
  end

  assign valid_o = valid_q;
  assign val_o   = val_q;
  assign age_o   = age_q;
endmodule

>>> tb/swis_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Interval statistics checker
// Watches both channels, predicts every result from the accepted items and
// compares each result transfer field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module swis_checker import swis_pkg::*; #(
  parameter int unsigned WINDOW = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swis_in_if.sink    in_mon,
  swis_out_if.sink   out_mon,
  output int         fail_count_o,
  output int         pending_o
);
  logic [IvW-1:0]  ring_q [WINDOW];
  int unsigned     wr_ptr;
  int unsigned     fill;
  longint unsigned sum;
  logic [CntW-1:0] presents, occluded, failed;
  out_item_t       stats_q [$];

  assign pending_o = stats_q.size();

  function automatic out_item_t compute_stats();
    out_item_t       r;
    logic [IvW-1:0]  srt [$];
    int unsigned     mid, rank;
    r = '0;
    if (fill > 0) begin
      for (int i = 0; i < fill; i++) srt = {srt, ring_q[i]};
      srt.sort();
      mid  = fill / 2;
      rank = (95 * (fill - 1) + 50) / 100;
      if (rank >= fill) rank = fill - 1;
      r.mean_us = IvW'(sum / fill);
      if (fill % 2) r.median_us = srt[mid];
      else r.median_us = IvW'(({1'b0, srt[mid-1]} + {1'b0, srt[mid]}) >> 1);
      r.p95_us = srt[rank];
      r.max_us = srt[fill-1];
    end
    r.window_count    = 8'(fill);
    r.presented_count = presents;
    r.occluded_count  = occluded;
    r.failed_count    = failed;
    return r;
  endfunction

  task automatic clear_stats();
    wr_ptr = 0; fill = 0; sum = 0;
    presents = '0; occluded = '0; failed = '0;
  endtask

  task automatic apply_item(in_item_t it);
    if (it.opcode == OP_CLEAR) begin
      clear_stats();
    end else begin
      presents++;
      if (it.present_status == StatusOccluded) occluded++;
      if (it.present_status[StatusFailBit]) failed++;
      if (fill >= WINDOW) sum -= ring_q[wr_ptr];
      ring_q[wr_ptr] = it.interval_us;
      sum += it.interval_us;
      wr_ptr = (wr_ptr + 1) % WINDOW;
      if (fill < WINDOW) fill++;
    end
    stats_q = {stats_q, compute_stats()};
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t exp;
    if (stats_q.size() == 0) begin
      $display("%0t: result with nothing expected: %p", $time, got);
      fail_count_o++;
      return;
    end
    exp = stats_q.pop_front();
    if (got.mean_us != exp.mean_us) begin
      $display("%0t: mean exp %0d got %0d", $time, exp.mean_us, got.mean_us);
      fail_count_o++;
    end
    if (got.median_us != exp.median_us) begin
      $display("%0t: median exp %0d got %0d", $time, exp.median_us, got.median_us);
      fail_count_o++;
    end
    if (got.p95_us != exp.p95_us) begin
      $display("%0t: p95 exp %0d got %0d", $time, exp.p95_us, got.p95_us);
      fail_count_o++;
    end
    if (got.max_us != exp.max_us) begin
      $display("%0t: max exp %0d got %0d", $time, exp.max_us, got.max_us);
      fail_count_o++;
    end
    if (got.window_count != exp.window_count) begin
      $display("%0t: count exp %0d got %0d", $time, exp.window_count,
               got.window_count);
      fail_count_o++;
    end
    if (got.presented_count != exp.presented_count) begin
      $display("%0t: presented exp %0d got %0d", $time, exp.presented_count,
               got.presented_count);
      fail_count_o++;
    end
    if (got.occluded_count != exp.occluded_count) begin
      $display("%0t: occluded exp %0d got %0d", $time, exp.occluded_count,
               got.occluded_count);
      fail_count_o++;
    end
    if (got.failed_count != exp.failed_count) begin
      $display("%0t: failed exp %0d got %0d", $time, exp.failed_count,
               got.failed_count);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    clear_stats();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready) apply_item(in_mon.data);
      if (out_mon.valid && out_mon.ready) compare_result(out_mon.data);
    end
  end
endmodule

>>> tb/tb_sliding_window_interval_stats.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Interval statistics testbench
// Drives directed and random record and clear items with random idling and
// a long result hold-off, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_sliding_window_interval_stats;
  import swis_pkg::*;

  localparam int unsigned WINDOW   = 128;
  localparam int unsigned N_RANDOM = 2000;
  localparam int          STALL_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   calm;       // no idling on either side while set
  bit   hold_off;   // receiver holds back results while set

  swis_in_if  in_if ();
  swis_out_if out_if ();

  sliding_window_interval_stats #(.WINDOW(WINDOW)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  swis_checker #(.WINDOW(WINDOW)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if.sink),
    .out_mon      (out_if.sink),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offers one item and holds it until its transfer, with random gaps before.
  // Valid stays high on return; the next call or the caller lowers it.
  task automatic send_item(opcode_e op, logic [IvW-1:0] iv, logic [1:0] st);
    while (!calm && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{opcode: op, interval_us: iv, present_status: st};
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // Mostly small or clustered intervals so that ties and ordering matter.
  function automatic logic [IvW-1:0] rand_interval();
    case ($urandom_range(3))
      0: return IvW'($urandom);
      1: return IvW'($urandom_range(16000, 17000));
      2: return IvW'($urandom_range(7));
      default: return $urandom_range(1) ? {IvW{1'b1}} - IvW'($urandom_range(3)) : '0;
    endcase
  endfunction

  // Receiver side.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= !hold_off && (calm || $urandom_range(99) >= 10);
    end
  end

  // Watchdog on cycles with no transfer at all, not counted during the hold-off.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else if (!hold_off)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    rst_ni      = 1'b0;
    idle_cycles = 0;
    calm = 1'b0; hold_off = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty clear, extremes, every status, odd and even counts.
    send_item(OP_CLEAR, '0, 2'd0);
    send_item(OP_RECORD, {IvW{1'b1}}, 2'd0);
    send_item(OP_RECORD, '0, 2'd1);
    send_item(OP_RECORD, {IvW{1'b1}}, 2'd2);
    send_item(OP_RECORD, 24'h555555, 2'd3);
    send_item(OP_RECORD, 24'hAAAAAA, 2'd3);
    send_item(OP_RECORD, 24'd1, 2'd1);
    send_item(OP_CLEAR, {IvW{1'b1}}, 2'd3);
    send_item(OP_RECORD, 24'd100, 2'd0);
    send_item(OP_RECORD, 24'd101, 2'd2);
    send_item(OP_CLEAR, '0, 2'd1);

    // Fill past the window with a receiver hold-off that also stalls the input.
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < WINDOW + 40; i++)
        send_item(OP_RECORD, rand_interval(), 2'($urandom_range(3)));
    join

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 600 && i < 900);
      if ($urandom_range(299) == 0) send_item(OP_CLEAR, rand_interval(), 2'($urandom));
      else send_item(OP_RECORD, rand_interval(), 2'($urandom_range(3)));
    end
    in_if.valid <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (WINDOW + 100) @(posedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

>>> sliding_window_interval_stats.f
+incdir+design
design/swis_pkg.sv
design/swis_if.sv
design/swis_div.sv
design/swis_cell.sv
design/sliding_window_interval_stats.sv
tb/swis_checker.sv
tb/tb_sliding_window_interval_stats.sv
